@@ rtl/mexp_pkg.sv @@
// ============================================================================
// mexp_pkg
// Shared types, constants and the microcode program of the modular
// exponentiation core.
// ============================================================================
package mexp_pkg;

    localparam int DATA_W            = 32;
    localparam int OPERAND_WIDTH_DEF = 32;
    localparam logic [DATA_W-1:0] MODULUS_RESET = 32'd1;

    localparam int PC_W = 4;

    // program step addresses
    localparam logic [PC_W-1:0] PC_IDLE     = 4'd0;
    localparam logic [PC_W-1:0] PC_TEST_MOD = 4'd1;
    localparam logic [PC_W-1:0] PC_TEST_EXP = 4'd2;
    localparam logic [PC_W-1:0] PC_REDUCE   = 4'd3;
    localparam logic [PC_W-1:0] PC_TEST_BIT = 4'd4;
    localparam logic [PC_W-1:0] PC_MULTIPLY = 4'd5;
    localparam logic [PC_W-1:0] PC_SQUARE   = 4'd6;
    localparam logic [PC_W-1:0] PC_LOOP     = 4'd7;
    localparam logic [PC_W-1:0] PC_EMIT_ACC = 4'd8;
    localparam logic [PC_W-1:0] PC_EMIT_ONE = 4'd9;
    localparam logic [PC_W-1:0] PC_EMIT_ERR = 4'd10;

    typedef enum logic [1:0] {
        MUL_NONE   = 2'd0,
        MUL_REDUCE = 2'd1,   // sq  <- base * 1 mod m
        MUL_ACC    = 2'd2,   // acc <- acc * sq mod m
        MUL_SQUARE = 2'd3    // sq  <- sq * sq mod m
    } mul_op_t;

    typedef enum logic [1:0] {
        EMIT_NONE = 2'd0,
        EMIT_ACC  = 2'd1,
        EMIT_ONE  = 2'd2,
        EMIT_ERR  = 2'd3
    } emit_t;

    typedef enum logic [2:0] {
        COND_NEXT     = 3'd0,
        COND_ALWAYS   = 3'd1,
        COND_MOD_ZERO = 3'd2,
        COND_EXP_ZERO = 3'd3,
        COND_BIT_CLR  = 3'd4,
        COND_EXP_NZ   = 3'd5
    } cond_t;

    typedef struct packed {
        logic            wait_in;
        mul_op_t         mul;
        emit_t           emit;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ucode_t;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic in_valid;
        logic mul_done;
        logic out_free;
        logic mod_zero;
        logic exp_zero;
        logic exp_lsb;
        logic exp_nz;
    } mexp_stat_t;

    // per-cycle strobes from the sequencer
    typedef struct packed {
        logic    in_beat;
        logic    mul_start;
        logic    mul_fin;
        logic    emit_go;
        mul_op_t mul;
        emit_t   emit;
    } mexp_ctrl_t;

    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        w = '{wait_in: 1'b0, mul: MUL_NONE, emit: EMIT_NONE,
              cond: COND_ALWAYS, target: PC_IDLE};
        unique case (pc)
            PC_IDLE:     w = '{1'b1, MUL_NONE,   EMIT_NONE, COND_NEXT,     PC_IDLE};
            PC_TEST_MOD: w = '{1'b0, MUL_NONE,   EMIT_NONE, COND_MOD_ZERO, PC_EMIT_ERR};
            PC_TEST_EXP: w = '{1'b0, MUL_NONE,   EMIT_NONE, COND_EXP_ZERO, PC_EMIT_ONE};
            PC_REDUCE:   w = '{1'b0, MUL_REDUCE, EMIT_NONE, COND_NEXT,     PC_IDLE};
            PC_TEST_BIT: w = '{1'b0, MUL_NONE,   EMIT_NONE, COND_BIT_CLR,  PC_SQUARE};
            PC_MULTIPLY: w = '{1'b0, MUL_ACC,    EMIT_NONE, COND_NEXT,     PC_IDLE};
            PC_SQUARE:   w = '{1'b0, MUL_SQUARE, EMIT_NONE, COND_NEXT,     PC_IDLE};
            PC_LOOP:     w = '{1'b0, MUL_NONE,   EMIT_NONE, COND_EXP_NZ,   PC_TEST_BIT};
            PC_EMIT_ACC: w = '{1'b0, MUL_NONE,   EMIT_ACC,  COND_ALWAYS,   PC_IDLE};
            PC_EMIT_ONE: w = '{1'b0, MUL_NONE,   EMIT_ONE,  COND_ALWAYS,   PC_IDLE};
            PC_EMIT_ERR: w = '{1'b0, MUL_NONE,   EMIT_ERR,  COND_ALWAYS,   PC_IDLE};
            default:     w = '{1'b0, MUL_NONE,   EMIT_NONE, COND_ALWAYS,   PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

@@ rtl/modular_exponentiation_core.sv @@
// ============================================================================
// modular_exponentiation_core
// base ** exponent mod modulus by right-to-left square-and-multiply,
// run by a microcoded sequencer around a bit-serial modular multiplier.
// ============================================================================
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  in      | in_valid, in_ready, base, exponent   | to core
//  out     | out_valid, out_ready, power_result,  | from core
//          | zero_modulus_error                   |
//  cfg     | cfg_wr_en, cfg_wr_data (modulus)     | to core
//
// One item at a time. A modular multiply works one multiplier bit per cycle
// (W = OPERAND_WIDTH); an item takes longer for long exponents, while a zero
// exponent or a zero modulus skips the multiplies. A finished result waits
// in the output register while the next beat is taken; the core stalls on
// the output only when it must emit a second one.
// Reset sets the modulus to 1 and empties the output register.
// ============================================================================
module modular_exponentiation_core #(
    parameter int OPERAND_WIDTH = mexp_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [mexp_pkg::DATA_W-1:0] cfg_wr_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [mexp_pkg::DATA_W-1:0] base,
    input  logic [mexp_pkg::DATA_W-1:0] exponent,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [mexp_pkg::DATA_W-1:0] power_result,
    output logic                        zero_modulus_error
);

    localparam int W  = OPERAND_WIDTH;
    localparam int DW = mexp_pkg::DATA_W;

    logic [DW-1:0] modulus_reg;
    logic [W-1:0]  base_reg;
    logic [W-1:0]  exp_reg;
    logic [W-1:0]  acc_reg;
    logic [W-1:0]  sq_reg;
    logic          out_valid_reg;
    logic [DW-1:0] result_reg;
    logic          err_reg;

    logic [W-1:0]  m;
    logic [W-1:0]  mul_a;
    logic [W-1:0]  mul_b;
    logic [W-1:0]  mul_res;
    logic          mul_done;

    mexp_pkg::mexp_stat_t stat;
    mexp_pkg::mexp_ctrl_t ctrl;

    assign m = modulus_reg[W-1:0];

    always_comb
    begin
        stat.in_valid = in_valid;
        stat.mul_done = mul_done;
        stat.out_free = !out_valid_reg || out_ready;
        stat.mod_zero = (m == '0);
        stat.exp_zero = (exp_reg == '0);
        stat.exp_lsb  = exp_reg[0];
        stat.exp_nz   = (exp_reg != '0);
    end

    mexp_useq u_useq (
        .clk      (clk),
        .rst_n    (rst_n),
        .stat     (stat),
        .in_ready (in_ready),
        .ctrl     (ctrl)
    );

    always_comb
    begin
        case (ctrl.mul)
            mexp_pkg::MUL_REDUCE:
            begin
                mul_a = base_reg;
                mul_b = W'(1);
            end
            mexp_pkg::MUL_ACC:
            begin
                mul_a = acc_reg;
                mul_b = sq_reg;
            end
            default:
            begin
                mul_a = sq_reg;
                mul_b = sq_reg;
            end
        endcase
    end

    mexp_modmul #(
        .OPERAND_WIDTH (W)
    ) u_modmul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (ctrl.mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .m      (m),
        .done   (mul_done),
        .result (mul_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            modulus_reg <= mexp_pkg::MODULUS_RESET;
        else if (cfg_wr_en)
            modulus_reg <= cfg_wr_data;
    end

    // operand registers
    always_ff @(posedge clk)
    begin
        if (ctrl.in_beat)
        begin
            base_reg <= base[W-1:0];
            exp_reg  <= exponent[W-1:0];
            acc_reg  <= W'(1);
        end
        else if (ctrl.mul_fin)
        begin
            case (ctrl.mul)
                mexp_pkg::MUL_ACC:
                    acc_reg <= mul_res;
                mexp_pkg::MUL_SQUARE:
                begin
                    sq_reg  <= mul_res;
                    exp_reg <= exp_reg >> 1;
                end
                default:
                    sq_reg <= mul_res;
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctrl.emit_go)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.emit_go)
        begin
            case (ctrl.emit)
                mexp_pkg::EMIT_ACC:
                begin
                    result_reg <= DW'(acc_reg);
                    err_reg    <= 1'b0;
                end
                mexp_pkg::EMIT_ONE:
                begin
                    result_reg <= DW'(1);
                    err_reg    <= 1'b0;
                end
                default:
                begin
                    result_reg <= '0;
                    err_reg    <= 1'b1;
                end
            endcase
        end
    end

    assign out_valid          = out_valid_reg;
    assign power_result       = result_reg;
    assign zero_modulus_error = err_reg;

endmodule

@@ rtl/mexp_modmul.sv @@
// ============================================================================
// mexp_modmul
// Interleaved modular multiplier: result = a * b mod m, one bit of a per
// cycle from the MSB. Requires b <= m and m != 0; a may be any value.
// ============================================================================
module mexp_modmul #(
    parameter int OPERAND_WIDTH = mexp_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [OPERAND_WIDTH-1:0] a,
    input  logic [OPERAND_WIDTH-1:0] b,
    input  logic [OPERAND_WIDTH-1:0] m,
    output logic                     done,
    output logic [OPERAND_WIDTH-1:0] result
);

    localparam int W  = OPERAND_WIDTH;
    localparam int CW = $clog2(W);

    logic [W-1:0]  a_reg;
    logic [W-1:0]  b_reg;
    logic [W-1:0]  r_reg;
    logic [W-1:0]  r_next;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [W:0] dbl;
    logic [W:0] dbl_red;
    logic [W:0] sum;
    logic [W:0] sum_red;
    logic [W:0] m_ext;

    always_comb
    begin
        m_ext   = {1'b0, m};
        dbl     = {r_reg, 1'b0};
        dbl_red = (dbl >= m_ext) ? dbl - m_ext : dbl;
        sum     = {1'b0, dbl_red[W-1:0]} + (a_reg[W-1] ? {1'b0, b_reg} : '0);
        sum_red = (sum >= m_ext) ? sum - m_ext : sum;
        r_next  = sum_red[W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
            r_reg <= '0;
        end
        else if (busy_reg)
        begin
            a_reg <= a_reg << 1;
            r_reg <= r_next;
        end
    end

    assign done   = done_reg;
    assign result = r_reg;

endmodule

@@ rtl/mexp_useq.sv @@
// ============================================================================
// mexp_useq
// Microcode sequencer: program counter over the control ROM, stall
// handling for input, multiplier and output, and conditional jumps.
// ============================================================================
module mexp_useq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mexp_pkg::mexp_stat_t stat,
    output logic                 in_ready,
    output mexp_pkg::mexp_ctrl_t ctrl
);

    logic [mexp_pkg::PC_W-1:0] pc_reg;
    logic [mexp_pkg::PC_W-1:0] pc_next;
    logic                      mul_run_reg;
    logic                      mul_run_next;
    mexp_pkg::ucode_t          word;
    logic                      has_mul;
    logic                      has_emit;
    logic                      hold;
    logic                      take;

    always_comb
    begin
        word     = mexp_pkg::ucode_rom(pc_reg);
        has_mul  = (word.mul != mexp_pkg::MUL_NONE);
        has_emit = (word.emit != mexp_pkg::EMIT_NONE);

        hold = (word.wait_in && !stat.in_valid)
            || (has_mul && !(mul_run_reg && stat.mul_done))
            || (has_emit && !stat.out_free);

        unique case (word.cond)
            mexp_pkg::COND_NEXT:     take = 1'b0;
            mexp_pkg::COND_ALWAYS:   take = 1'b1;
            mexp_pkg::COND_MOD_ZERO: take = stat.mod_zero;
            mexp_pkg::COND_EXP_ZERO: take = stat.exp_zero;
            mexp_pkg::COND_BIT_CLR:  take = !stat.exp_lsb;
            mexp_pkg::COND_EXP_NZ:   take = stat.exp_nz;
            default:                 take = 1'b0;
        endcase

        if (hold)
            pc_next = pc_reg;
        else if (take)
            pc_next = word.target;
        else
            pc_next = pc_reg + 1'b1;

        ctrl.in_beat   = word.wait_in && stat.in_valid;
        ctrl.mul_start = has_mul && !mul_run_reg;
        ctrl.mul_fin   = has_mul && mul_run_reg && stat.mul_done;
        ctrl.emit_go   = has_emit && stat.out_free;
        ctrl.mul       = word.mul;
        ctrl.emit      = word.emit;

        if (ctrl.mul_start)
            mul_run_next = 1'b1;
        else if (ctrl.mul_fin)
            mul_run_next = 1'b0;
        else
            mul_run_next = mul_run_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg      <= mexp_pkg::PC_IDLE;
            mul_run_reg <= 1'b0;
        end
        else
        begin
            pc_reg      <= pc_next;
            mul_run_reg <= mul_run_next;
        end
    end

    assign in_ready = word.wait_in;

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Checks modular_exponentiation_core against a square-and-multiply predictor
// over several modulus settings: reset value, zero, one, all-ones, powers of
// two and random. Both handshakes see random idle cycles.
// ============================================================================
module testbench;

    localparam int W = mexp_pkg::DATA_W;
    localparam int RANDOM_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 35;

    typedef struct packed {
        logic [W-1:0] value;
        logic         err;
    } pow_result_t;

    // expected powers, in the order the inputs were taken
    class pow_scoreboard;
        logic [W-1:0] modulus;
        pow_result_t  expected_q[$];
        int           mismatches;
        int           checked;
        int           errors_seen;

        function new();
            modulus = mexp_pkg::MODULUS_RESET;
            mismatches = 0;
            checked = 0;
            errors_seen = 0;
        endfunction

        function pow_result_t predict_power(logic [W-1:0] b, logic [W-1:0] e);
            logic [63:0] m;
            logic [63:0] sq;
            logic [63:0] acc;
            pow_result_t r;
            m = 64'(modulus);
            if (m == 0)
            begin
                r.value = '0;
                r.err = 1'b1;
                return r;
            end
            r.err = 1'b0;
            if (e == 0)
            begin
                r.value = W'(1);
                return r;
            end
            sq = 64'(b) % m;
            acc = 64'd1;
            for (int i = 0; i < W; i++)
            begin
                if (e[i])
                    acc = (acc * sq) % m;
                sq = (sq * sq) % m;
            end
            r.value = acc[W-1:0];
            return r;
        endfunction

        function void note_input(logic [W-1:0] b, logic [W-1:0] e);
            expected_q.push_back(predict_power(b, e));
        endfunction

        function void check_result(logic [W-1:0] value, logic err);
            pow_result_t want;
            checked++;
            if (err)
                errors_seen++;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected beat, power %h err %b", value, err);
                return;
            end
            want = expected_q.pop_front();
            if (value !== want.value || err !== want.err)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: power %h err %b, expected %h err %b (modulus %h)",
                             value, err, want.value, want.err, modulus);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         cfg_wr_en;
    logic [W-1:0] cfg_wr_data;
    logic         in_valid;
    logic         in_ready;
    logic [W-1:0] base;
    logic [W-1:0] exponent;
    logic         out_valid;
    logic         out_ready;
    logic [W-1:0] power_result;
    logic         zero_modulus_error;

    pow_scoreboard board = new;
    bit            steady;        // no idle cycles on either side
    int            modulus_writes;

    modular_exponentiation_core uut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .base               (base),
        .exponent           (exponent),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .power_result       (power_result),
        .zero_modulus_error (zero_modulus_error)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // worst case is about 300 items, each of the longest kind
    initial
    begin
        #30_000_000;
        $display("Mismatches found");
        $finish;
    end

    task automatic send_item(input logic [W-1:0] b, input logic [W-1:0] e);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        base     <= b;
        exponent <= e;
        do @(posedge clk); while (!in_ready);
        board.note_input(b, e);
    endtask

    // let every pending result come out before the modulus may change
    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_modulus(input logic [W-1:0] m);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        board.modulus = m;
        modulus_writes++;
    endtask

    // result side
    initial
    begin
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            gap = steady ? 0 : $urandom_range(0, 3);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            board.check_result(power_result, zero_modulus_error);
        end
    end

    initial
    begin
        logic [W-1:0] b;
        logic [W-1:0] e;
        logic [W-1:0] m;
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        in_valid       = 1'b0;
        base           = '0;
        exponent       = '0;
        steady         = 1'b0;
        modulus_writes = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // modulus still at its reset value of one: only a zero exponent gives 1
        send_item(32'd5, 32'd0);
        send_item(32'd0, 32'd0);
        send_item('1, '1);
        send_item(32'd7, 32'd1);
        drain();

        // zero modulus flags an error even for a zero exponent
        set_modulus('0);
        send_item(32'd0, 32'd0);
        send_item('1, '1);
        send_item(32'd3, 32'd5);
        drain();

        set_modulus('1);
        send_item(32'd0, 32'd0);
        send_item(32'd0, 32'd5);
        send_item('1, 32'd1);
        send_item('1, '1);
        send_item(32'hFFFF_FFFE, 32'd2);
        send_item(32'd2, 32'h8000_0000);
        send_item(32'h075B_CD15, '1);
        send_item(32'd1, $urandom);
        send_item(32'h8000_0001, 32'd3);
        drain();

        // prime modulus, bases above, at and below it
        set_modulus(32'hFFFF_FFFB);
        send_item(32'hFFFF_FFFD, 32'd3);
        send_item(32'hFFFF_FFFB, 32'd7);
        send_item(32'd2, 32'hFFFF_FFFA);
        drain();

        set_modulus(32'd1);
        send_item(32'd9, 32'd0);
        send_item(32'd9, 32'd9);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:       m = 32'd2;
                1:       m = '1;
                2:       m = $urandom_range(3, 255);
                3:       m = '0;
                4:       m = 32'h8000_0000;
                5:       m = $urandom;
                6:       m = $urandom | 32'h8000_0000;
                default: m = $urandom_range(2, 65535);
            endcase
            set_modulus(m);
            steady = (p % 3 == 2);
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                case ($urandom_range(0, 9))
                    0:       b = '0;
                    1:       b = '1;
                    2:       b = m + $urandom_range(0, 3);
                    3:       b = $urandom_range(0, 15);
                    default: b = $urandom;
                endcase
                case ($urandom_range(0, 9))
                    0:       e = '0;
                    1:       e = '1;
                    2, 3:    e = $urandom_range(1, 64);
                    4:       e = 32'd1 << $urandom_range(0, 31);
                    default: e = $urandom;
                endcase
                send_item(b, e);
            end
            drain();
        end
        steady = 1'b0;

        $display("Run covered %0d results under %0d modulus writes, %0d flagged zero modulus",
                 board.checked, modulus_writes, board.errors_seen);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ modular_exponentiation_core.f @@
rtl/mexp_pkg.sv
rtl/mexp_modmul.sv
rtl/mexp_useq.sv
rtl/modular_exponentiation_core.sv
test/testbench.sv
